### design/tow_pkg.sv
// Types, codes and the option kind table shared by the TCP option walker.
package tow_pkg;

    localparam logic [1:0] PH_KIND = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_NOLEN   = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;
    localparam logic [2:0] ST_BADLEN  = 3'd5;

    localparam logic [7:0] KIND_EOL      = 8'd0;
    localparam logic [7:0] KIND_NOP      = 8'd1;
    localparam logic [7:0] KIND_MSS      = 8'd2;
    localparam logic [7:0] KIND_WSCALE   = 8'd3;
    localparam logic [7:0] KIND_SACK_OK  = 8'd4;
    localparam logic [7:0] KIND_SACK     = 8'd5;
    localparam logic [7:0] KIND_TSTAMP   = 8'd8;
    localparam logic [7:0] KIND_MD5      = 8'd19;
    localparam logic [7:0] KIND_FASTOPEN = 8'd34;
    localparam logic [7:0] KIND_EXPER    = 8'd254;

    localparam logic [7:0] LEN_MSS     = 8'd4;
    localparam logic [7:0] LEN_WSCALE  = 8'd3;
    localparam logic [7:0] LEN_SACK_OK = 8'd2;
    localparam logic [7:0] LEN_TSTAMP  = 8'd10;
    localparam logic [7:0] LEN_MIN     = 8'd2;
    localparam logic [7:0] LEN_SINGLE  = 8'd1;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] current_kind;
        logic [7:0] fixed_length;
        logic [7:0] declared_length;
        logic [7:0] bytes_seen;
        logic [5:0] area_offset;
        logic [5:0] option_start;
        logic       error_latched;
        logic       mismatch_pending;
    } walk_state_t;

    localparam walk_state_t STATE_RESET = '{
        phase: PH_KIND, current_kind: 8'd0, fixed_length: 8'd0,
        declared_length: 8'd0, bytes_seen: 8'd0, area_offset: 6'd0,
        option_start: 6'd0, error_latched: 1'b0, mismatch_pending: 1'b0
    };

    typedef struct packed {
        logic [7:0] option_kind;
        logic [5:0] start_offset;
        logic [7:0] option_length;
        logic [2:0] status;
        logic       area_done;
    } walk_result_t;

    typedef struct packed {
        logic       known;
        logic [7:0] length;
    } kind_info_t;

    // Length 1 marks a single-byte kind and length 0 a variable-length kind.
    function automatic kind_info_t kind_lookup(input logic [7:0] kind);
        kind_info_t info;
        info = '{known: 1'b1, length: 8'd0};
        unique case (kind) inside
            KIND_EOL, KIND_NOP: info.length = LEN_SINGLE;
            KIND_MSS:           info.length = LEN_MSS;
            KIND_WSCALE:        info.length = LEN_WSCALE;
            KIND_SACK_OK:       info.length = LEN_SACK_OK;
            KIND_TSTAMP:        info.length = LEN_TSTAMP;
            KIND_SACK, KIND_MD5, KIND_FASTOPEN, KIND_EXPER:
                                info.length = 8'd0;
            default:            info.known  = 1'b0;
        endcase
        return info;
    endfunction

endpackage

### design/tcp_option_walker.sv
// Top level of the TCP option walker: byte input register, walk state and result register.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata: option_byte; tlast: last_byte
//  m_axis   out        tdata: option_kind, start_offset, option_length, status; tlast: area_done
//
// One byte is taken per clock unless a stalled result holds it back; a byte is held in the input
// register, and its result is then registered in the result register.
// The walk state and both valid flags clear on rst_n low, asynchronously.
// A stalled result holds the input register, which in turn drops s_axis_tready.
module tcp_option_walker
    import tow_pkg::*;
#(
    parameter int MAX_AREA_BYTES = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] option_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] kind, [13:8] start, [21:14] length, [24:22] status
    output logic        m_axis_tlast    // area_done
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    walk_state_t  state_reg;
    walk_state_t  state_next;
    logic         out_valid_reg;
    walk_result_t out_reg;
    walk_result_t result;
    logic         result_valid;
    logic         area_end;
    logic         advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    tow_step #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES)
    ) u_step (
        .state        (state_reg),
        .option_byte  (in_byte_reg),
        .last_byte    (in_last_reg),
        .state_next   (state_next),
        .result_valid (result_valid),
        .result       (result),
        .area_end     (area_end)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= result_valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && result_valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.status, out_reg.option_length,
                            out_reg.start_offset, out_reg.option_kind};
    assign m_axis_tlast  = out_reg.area_done;

`ifndef SYNTHESIS
    a_error_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.status != ST_OK |-> m_axis_tlast)
        else $error("error result without area_done");

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.area_offset < 6'(MAX_AREA_BYTES))
        else $error("area offset beyond area size");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && area_end |=> state_reg.area_offset == 6'd0 && !state_reg.error_latched)
        else $error("walk did not restart after area end");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.error_latched |-> !result_valid)
        else $error("result produced after an error");
`endif

endmodule

### design/tow_step.sv
// Next-state and result logic for one byte of the TCP option area.
module tow_step
    import tow_pkg::*;
#(
    parameter int MAX_AREA_BYTES = 40
)
(
    input  walk_state_t  state,
    input  logic [7:0]   option_byte,
    input  logic         last_byte,
    output walk_state_t  state_next,
    output logic         result_valid,
    output walk_result_t result,
    output logic         area_end
);

    localparam logic [5:0] LAST_OFFSET = 6'(MAX_AREA_BYTES - 1);

    logic        last;
    logic        mismatch;
    logic [7:0]  seen;
    kind_info_t  info;

    assign last = last_byte || (state.area_offset >= LAST_OFFSET);
    assign area_end = last;

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;
        mismatch     = state.fixed_length != 8'd0 && option_byte != state.fixed_length;
        seen         = state.bytes_seen + 8'd1;
        info         = kind_lookup(option_byte);
        if (!state.error_latched)
        begin
            unique case (state.phase)
                PH_LEN:
                begin
                    state_next.declared_length = option_byte;
                    state_next.bytes_seen      = LEN_MIN;
                    result = '{option_kind: state.current_kind,
                               start_offset: state.option_start,
                               option_length: option_byte,
                               status: ST_OK, area_done: 1'b1};
                    if (option_byte < LEN_MIN)
                    begin
                        result.status            = ST_SHORT;
                        result_valid             = 1'b1;
                        state_next.error_latched = 1'b1;
                    end
                    else
                    begin
                        state_next.mismatch_pending = mismatch;
                        if (option_byte == LEN_MIN)
                        begin
                            result.status            = mismatch ? ST_BADLEN : ST_OK;
                            result.area_done         = mismatch || last;
                            result_valid             = 1'b1;
                            state_next.error_latched = mismatch;
                            state_next.phase         = PH_KIND;
                        end
                        else if (last)
                        begin
                            result.status            = ST_OVERRUN;
                            result_valid             = 1'b1;
                            state_next.error_latched = 1'b1;
                        end
                        else
                        begin
                            state_next.phase = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    state_next.bytes_seen = seen;
                    result = '{option_kind: state.current_kind,
                               start_offset: state.option_start,
                               option_length: state.declared_length,
                               status: ST_OVERRUN, area_done: 1'b1};
                    if (seen >= state.declared_length)
                    begin
                        result.status            = state.mismatch_pending ? ST_BADLEN : ST_OK;
                        result.area_done         = state.mismatch_pending || last;
                        result_valid             = 1'b1;
                        state_next.error_latched = state.mismatch_pending;
                        state_next.phase         = PH_KIND;
                    end
                    else if (last)
                    begin
                        result_valid             = 1'b1;
                        state_next.error_latched = 1'b1;
                    end
                end
                default:
                begin
                    state_next.current_kind     = option_byte;
                    state_next.option_start     = state.area_offset;
                    state_next.mismatch_pending = 1'b0;
                    state_next.declared_length  = 8'd0;
                    state_next.bytes_seen       = 8'd1;
                    state_next.fixed_length     = info.length;
                    result = '{option_kind: option_byte,
                               start_offset: state.area_offset,
                               option_length: 8'd0,
                               status: ST_UNKNOWN, area_done: 1'b1};
                    if (!info.known)
                    begin
                        result_valid             = 1'b1;
                        state_next.error_latched = 1'b1;
                    end
                    else if (info.length == LEN_SINGLE)
                    begin
                        result.option_length = LEN_SINGLE;
                        result.status        = ST_OK;
                        result.area_done     = last;
                        result_valid         = 1'b1;
                    end
                    else if (last)
                    begin
                        result.status            = ST_NOLEN;
                        result_valid             = 1'b1;
                        state_next.error_latched = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = PH_LEN;
                    end
                end
            endcase
        end
        if (last)
        begin
            state_next = STATE_RESET;
        end
        else
        begin
            state_next.area_offset = state.area_offset + 6'd1;
        end
    end

endmodule
